@@ rtl/kts_pkg.sv @@
package kts_pkg;

   localparam int MAX_KEYS  = 64;
   localparam int SLOT_W    = $clog2(MAX_KEYS);
   localparam int CNT_W     = 7;
   localparam int ADDR_W    = SLOT_W + 2;
   localparam int RAM_DEPTH = 4 * MAX_KEYS;

   // Divider operand widths.
   localparam int NUM_W = 64;
   localparam int DEN_W = 32;

   // Square root operand widths.
   localparam int RAD_W  = 61;
   localparam int ROOT_W = 31;

   // CORDIC datapath widths.
   localparam int XY_W  = 34;
   localparam int ANG_W = 20;

   typedef enum logic [1:0] {
      OP_SAMPLE   = 2'd0,
      OP_LOAD_POS = 2'd1,
      OP_LOAD_ROT = 2'd2,
      OP_LOAD_SCL = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      TR_POS = 2'd0,
      TR_ROT = 2'd1,
      TR_SCL = 2'd2
   } track_type;

   // One key of a track: its time stamp and up to four components.
   typedef struct packed {
      logic [31:0]      stamp;
      logic [3:0][31:0] val;
   } key_type;

   localparam int KEY_W = $bits(key_type);

endpackage

@@ rtl/kts_ram.sv @@
module kts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/kts_div.sv @@
module kts_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [kts_pkg::NUM_W-1:0] dividend,
   input  logic [kts_pkg::DEN_W-1:0] divisor,
   output logic                      done,
   output logic [kts_pkg::NUM_W-1:0] quotient
);
   import kts_pkg::*;

   localparam int CNT_BITS = $clog2(NUM_W);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [DEN_W-1:0]    rem_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [NUM_W-1:0]    quo_ff;

   logic [DEN_W:0] rem_sh;
   logic [DEN_W:0] rem_sub;
   logic           fits;

   // Restoring division: one quotient bit per cycle, dividend bits shift out
   // of the top of the quotient register as quotient bits enter at the bottom.
   assign rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign fits    = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(NUM_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/kts_sqrt.sv @@
module kts_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [kts_pkg::RAD_W-1:0]  radicand,
   output logic                       done,
   output logic [kts_pkg::ROOT_W-1:0] root
);
   import kts_pkg::*;

   localparam int SW = RAD_W + 1;

   logic          busy_ff;
   logic          done_ff;
   logic [SW-1:0] v_ff;
   logic [SW-1:0] r_ff;
   logic [SW-1:0] b_ff;

   logic [SW-1:0] rb;
   logic          take;

   // Digit-by-digit square root, two radicand bits per cycle.
   assign rb   = r_ff + b_ff;
   assign take = v_ff >= rb;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && b_ff == SW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff <= SW'(radicand);
         r_ff <= '0;
         b_ff <= SW'(1) << (RAD_W - 1);
      end else if (busy_ff) begin
         if (take) begin
            v_ff <= v_ff - rb;
            r_ff <= (r_ff >> 1) + b_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         b_ff <= b_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = r_ff[ROOT_W-1:0];

endmodule

@@ rtl/kts_cordic.sv @@
module kts_cordic (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             vectoring,
   input  logic signed [kts_pkg::XY_W-1:0]  x_in,
   input  logic signed [kts_pkg::XY_W-1:0]  y_in,
   input  logic signed [kts_pkg::ANG_W-1:0] z_in,
   output logic                             done,
   output logic signed [kts_pkg::XY_W-1:0]  y_out,
   output logic signed [kts_pkg::ANG_W-1:0] z_out
);
   import kts_pkg::*;

   localparam int STEPS  = 16;
   localparam int STEP_W = $clog2(STEPS);
   localparam logic signed [XY_W-1:0] KINV = XY_W'(652032874);

   function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
      logic signed [ANG_W-1:0] a;
      case (i)
         4'd0:    a = ANG_W'(51472);
         4'd1:    a = ANG_W'(30386);
         4'd2:    a = ANG_W'(16055);
         4'd3:    a = ANG_W'(8150);
         4'd4:    a = ANG_W'(4091);
         4'd5:    a = ANG_W'(2047);
         4'd6:    a = ANG_W'(1024);
         4'd7:    a = ANG_W'(512);
         4'd8:    a = ANG_W'(256);
         4'd9:    a = ANG_W'(128);
         4'd10:   a = ANG_W'(64);
         4'd11:   a = ANG_W'(32);
         4'd12:   a = ANG_W'(16);
         4'd13:   a = ANG_W'(8);
         4'd14:   a = ANG_W'(4);
         default: a = ANG_W'(2);
      endcase
      return a;
   endfunction

   logic                    busy_ff;
   logic                    done_ff;
   logic                    mode_ff;
   logic [STEP_W-1:0]       step_ff;
   logic signed [XY_W-1:0]  x_ff;
   logic signed [XY_W-1:0]  y_ff;
   logic signed [ANG_W-1:0] z_ff;

   logic signed [XY_W-1:0]  dx;
   logic signed [XY_W-1:0]  dy;
   logic signed [ANG_W-1:0] at;
   logic                    up;

   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;
   assign at = atan_q16(step_ff);
   // Vectoring drives y toward zero; rotation drives the residual angle to zero.
   assign up = mode_ff ? (y_ff > 0) : (z_ff >= 0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mode_ff <= vectoring;
         x_ff    <= vectoring ? x_in : KINV;
         y_ff    <= vectoring ? y_in : '0;
         z_ff    <= vectoring ? '0 : z_in;
      end else if (busy_ff) begin
         if (mode_ff) begin
            if (up) begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + at;
            end else begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - at;
            end
         end else begin
            if (up) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + at;
            end
         end
      end
   end

   assign done  = done_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

@@ rtl/keyframe_trs_sampler.sv @@
// Keyframe sampler for position, rotation and scale tracks in Q16.16. Load
// items write one key into the key memory; sample items return one result
// with all ten components and a clamp flag. All keys live in one memory with
// one read port, so each track is searched one key per cycle. A bracketed
// position or scale track adds a fraction divide and a blend. A bracketed
// rotation adds the dot product and, unless the keys are nearly aligned, a
// square root, three 16-step CORDIC passes and four component divides. A
// sample is only started on an idle block; the finished item waits in the
// output register while the next item is taken. Key counts above the track
// depth act as the full depth.
module keyframe_trs_sampler (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_operation,
   input  logic [5:0]                        req_key_slot,
   input  logic [31:0]                       req_key_time,
   input  logic signed [31:0]                req_value_x,
   input  logic signed [31:0]                req_value_y,
   input  logic signed [31:0]                req_value_z,
   input  logic signed [31:0]                req_value_w,
   input  logic [31:0]                       req_sample_time,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_pos_x,
   output logic signed [31:0]                rsp_pos_y,
   output logic signed [31:0]                rsp_pos_z,
   output logic signed [31:0]                rsp_rot_x,
   output logic signed [31:0]                rsp_rot_y,
   output logic signed [31:0]                rsp_rot_z,
   output logic signed [31:0]                rsp_rot_w,
   output logic signed [31:0]                rsp_scl_x,
   output logic signed [31:0]                rsp_scl_y,
   output logic signed [31:0]                rsp_scl_z,
   output logic                              rsp_clamped,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [3:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import kts_pkg::*;

   localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
   localparam logic [1:0]  REG_POS   = 2'd0;
   localparam logic [1:0]  REG_ROT   = 2'd1;
   localparam logic [1:0]  REG_SCL   = 2'd2;
   localparam int          RES_N     = 10;

   typedef enum logic [4:0] {
      S_IDLE, S_TRACK, S_FIRST, S_SCAN, S_HOLD, S_FDIV_GO, S_FDIV,
      S_LERP_MUL, S_LERP_ADD, S_DOT_MUL, S_DOT_ADD, S_DOT_ABS, S_EDGE,
      S_SQRT_GO, S_SQRT, S_VEC_GO, S_VEC, S_ANG_MUL, S_ANG_SPLIT,
      S_SIN1_GO, S_SIN1, S_SIN2_GO, S_SIN2, S_CMP_MUL1, S_CMP_MUL2,
      S_CMP_SUM, S_CDIV_GO, S_CDIV, S_NEXT, S_DONE
   } state_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [3:0] res_base(input track_type tr);
      logic [3:0] b;
      case (tr)
         TR_POS:  b = 4'd0;
         TR_ROT:  b = 4'd3;
         default: b = 4'd7;
      endcase
      return b;
   endfunction

   // Configuration registers.
   logic [CNT_W-1:0] pos_cnt_ff;
   logic [CNT_W-1:0] rot_cnt_ff;
   logic [CNT_W-1:0] scl_cnt_ff;

   // Sequencer state.
   state_type          state_ff;
   track_type          tr_ff;
   logic [SLOT_W-1:0]  idx_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [1:0]         comp_ff;
   logic [31:0]        t_ff;
   logic               clamp_ff;
   logic               bneg_ff;
   logic               neg_ff;
   key_type            ent_a_ff;
   key_type            ent_b_ff;
   logic [15:0]        frac_ff;
   logic signed [49:0] dot_ff;
   logic [31:0]        sq_ff;
   logic [ROOT_W-1:0]  s30_ff;
   logic [16:0]        theta_ff;
   logic [16:0]        a1_ff;
   logic [16:0]        a2_ff;
   logic signed [31:0] s1_ff;
   logic signed [31:0] s2_ff;
   logic signed [63:0] prod_ff;
   logic signed [63:0] p2_ff;
   logic [NUM_W-1:0]   div_num_ff;
   logic [DEN_W-1:0]   div_den_ff;
   logic [31:0]        res_ff [RES_N];

   logic               rsp_valid_ff;
   logic               rsp_clamped_ff;
   logic [31:0]        rsp_ff [RES_N];

   // Memory and unit hookups.
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   key_type            wr_key;
   logic [ADDR_W-1:0]  rd_addr;
   logic [SLOT_W-1:0]  rd_slot;
   logic [KEY_W-1:0]   rd_raw;
   key_type            rd_key;
   track_type          ld_track;

   logic               div_start;
   logic               div_done;
   logic [NUM_W-1:0]   div_quo;
   logic               sqrt_start;
   logic               sqrt_done;
   logic [ROOT_W-1:0]  sqrt_root;
   logic [RAD_W-1:0]   radicand;
   logic               cor_start;
   logic               cor_vec;
   logic signed [XY_W-1:0]  cor_x;
   logic signed [XY_W-1:0]  cor_y;
   logic signed [ANG_W-1:0] cor_z;
   logic                    cor_done;
   logic signed [XY_W-1:0]  cor_y_out;
   logic signed [ANG_W-1:0] cor_z_out;

   // Per-component arithmetic.
   logic [CNT_W-1:0]   cnt_sel;
   logic [CNT_W-1:0]   n_eff;
   logic signed [31:0] a_s;
   logic signed [31:0] b_s;
   logic signed [33:0] av;
   logic signed [33:0] bv;
   logic signed [33:0] lerp_d;
   logic signed [63:0] lerp_sum;
   logic signed [63:0] cmp_sum;
   logic [1:0]         last_comp;
   logic [3:0]         res_idx;
   logic               sample_go;

   assign req_stall = state_ff != S_IDLE;
   assign sample_go = req_valid && !req_stall && op_type'(req_operation) == OP_SAMPLE;

   // ---------------- configuration port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_cnt_ff <= '0;
         rot_cnt_ff <= '0;
         scl_cnt_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            REG_POS: pos_cnt_ff <= csr_pwdata[CNT_W-1:0];
            REG_ROT: rot_cnt_ff <= csr_pwdata[CNT_W-1:0];
            REG_SCL: scl_cnt_ff <= csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_POS: csr_prdata = 32'(pos_cnt_ff);
         REG_ROT: csr_prdata = 32'(rot_cnt_ff);
         REG_SCL: csr_prdata = 32'(scl_cnt_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // ---------------- key memory ----------------
   always_comb begin
      case (op_type'(req_operation))
         OP_LOAD_POS: ld_track = TR_POS;
         OP_LOAD_ROT: ld_track = TR_ROT;
         default:     ld_track = TR_SCL;
      endcase
   end

   assign wr_en = req_valid && !req_stall && op_type'(req_operation) != OP_SAMPLE
                  && 32'(req_key_slot) < MAX_KEYS;
   assign wr_addr = {ld_track, SLOT_W'(req_key_slot)};

   always_comb begin
      wr_key.stamp  = req_key_time;
      wr_key.val[0] = req_value_x;
      wr_key.val[1] = req_value_y;
      wr_key.val[2] = req_value_z;
      wr_key.val[3] = req_value_w;
   end

   // The read address runs one key ahead of the key being compared.
   always_comb begin
      case (state_ff)
         S_FIRST: rd_slot = SLOT_W'(1);
         S_SCAN:  rd_slot = idx_ff + 1'b1;
         default: rd_slot = '0;
      endcase
   end

   assign rd_addr = {tr_ff, rd_slot};
   assign rd_key  = key_type'(rd_raw);

   kts_ram #(.WIDTH(KEY_W), .DEPTH(RAM_DEPTH)) u_keys (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_key),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // ---------------- arithmetic units ----------------
   assign div_start  = state_ff == S_FDIV_GO || state_ff == S_CDIV_GO;
   assign sqrt_start = state_ff == S_SQRT_GO;
   assign radicand   = (RAD_W'(1) << (RAD_W - 1)) - {sq_ff, 28'b0};
   assign cor_start  = state_ff == S_VEC_GO || state_ff == S_SIN1_GO
                       || state_ff == S_SIN2_GO;
   assign cor_vec    = state_ff == S_VEC_GO;
   assign cor_x      = $signed({3'b0, dot_ff[16:0], 14'b0});
   assign cor_y      = $signed({3'b0, s30_ff});
   assign cor_z      = $signed({3'b0, (state_ff == S_SIN1_GO) ? a1_ff : a2_ff});

   kts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num_ff),
      .divisor  (div_den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   kts_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   kts_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .start     (cor_start),
      .vectoring (cor_vec),
      .x_in      (cor_x),
      .y_in      (cor_y),
      .z_in      (cor_z),
      .done      (cor_done),
      .y_out     (cor_y_out),
      .z_out     (cor_z_out)
   );

   always_comb begin
      case (tr_ff)
         TR_POS:  cnt_sel = pos_cnt_ff;
         TR_ROT:  cnt_sel = rot_cnt_ff;
         default: cnt_sel = scl_cnt_ff;
      endcase
   end

   assign n_eff = (32'(cnt_sel) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : cnt_sel;

   assign a_s       = $signed(ent_a_ff.val[comp_ff]);
   assign b_s       = $signed(ent_b_ff.val[comp_ff]);
   assign av        = 34'(a_s);
   assign bv        = bneg_ff ? -34'(b_s) : 34'(b_s);
   assign lerp_d    = bv - av;
   assign lerp_sum  = 64'(av) + (prod_ff >>> 16);
   assign cmp_sum   = prod_ff + p2_ff;
   assign last_comp = (tr_ff == TR_ROT) ? 2'd3 : 2'd2;
   assign res_idx   = res_base(tr_ff) + 4'(comp_ff);

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         tr_ff          <= TR_POS;
         rsp_valid_ff   <= 1'b0;
         rsp_clamped_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (sample_go) begin
                  t_ff     <= req_sample_time;
                  tr_ff    <= TR_POS;
                  clamp_ff <= 1'b0;
                  state_ff <= S_TRACK;
               end
            end
            S_TRACK: begin
               n_ff    <= n_eff;
               bneg_ff <= 1'b0;
               if (n_eff == '0) begin
                  for (int c = 0; c < 4; c++) begin
                     if (c <= int'(last_comp)) begin
                        res_ff[4'(int'(res_base(tr_ff)) + c)] <=
                           (tr_ff == TR_SCL || (tr_ff == TR_ROT && c == 3)) ? ONE_Q16 : '0;
                     end
                  end
                  state_ff <= S_NEXT;
               end else begin
                  state_ff <= S_FIRST;
               end
            end
            S_FIRST: begin
               ent_a_ff <= rd_key;
               if (t_ff < rd_key.stamp) begin
                  clamp_ff <= 1'b1;
                  state_ff <= S_HOLD;
               end else if (n_ff == CNT_W'(1)) begin
                  if (t_ff > rd_key.stamp) begin
                     clamp_ff <= 1'b1;
                  end
                  state_ff <= S_HOLD;
               end else begin
                  idx_ff   <= SLOT_W'(1);
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (t_ff < rd_key.stamp) begin
                  ent_b_ff   <= rd_key;
                  div_num_ff <= {16'b0, t_ff - ent_a_ff.stamp, 16'b0};
                  div_den_ff <= rd_key.stamp - ent_a_ff.stamp;
                  state_ff   <= S_FDIV_GO;
               end else begin
                  ent_a_ff <= rd_key;
                  if (32'(idx_ff) + 32'd1 == 32'(n_ff)) begin
                     if (t_ff > rd_key.stamp) begin
                        clamp_ff <= 1'b1;
                     end
                     state_ff <= S_HOLD;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            S_HOLD: begin
               for (int c = 0; c < 4; c++) begin
                  if (c <= int'(last_comp)) begin
                     res_ff[4'(int'(res_base(tr_ff)) + c)] <= ent_a_ff.val[c];
                  end
               end
               state_ff <= S_NEXT;
            end
            S_FDIV_GO: state_ff <= S_FDIV;
            S_FDIV: begin
               if (div_done) begin
                  frac_ff <= div_quo[15:0];
                  comp_ff <= '0;
                  dot_ff  <= '0;
                  state_ff <= (tr_ff == TR_ROT) ? S_DOT_MUL : S_LERP_MUL;
               end
            end
            S_LERP_MUL: begin
               prod_ff  <= lerp_d * $signed({1'b0, frac_ff});
               state_ff <= S_LERP_ADD;
            end
            S_LERP_ADD: begin
               res_ff[res_idx] <= sat32(lerp_sum);
               comp_ff <= comp_ff + 1'b1;
               state_ff <= (comp_ff == last_comp) ? S_NEXT : S_LERP_MUL;
            end
            S_DOT_MUL: begin
               prod_ff  <= a_s * b_s;
               state_ff <= S_DOT_ADD;
            end
            S_DOT_ADD: begin
               dot_ff  <= dot_ff + 50'(prod_ff >>> 16);
               comp_ff <= comp_ff + 1'b1;
               state_ff <= (comp_ff == 2'd3) ? S_DOT_ABS : S_DOT_MUL;
            end
            S_DOT_ABS: begin
               // Take the shorter arc by flipping the far key.
               if (dot_ff < 0) begin
                  dot_ff  <= -dot_ff;
                  bneg_ff <= 1'b1;
               end
               state_ff <= S_EDGE;
            end
            S_EDGE: begin
               comp_ff <= '0;
               if (dot_ff > 50'sd65472) begin
                  state_ff <= S_LERP_MUL;
               end else begin
                  sq_ff    <= 32'(dot_ff[16:0]) * 32'(dot_ff[16:0]);
                  state_ff <= S_SQRT_GO;
               end
            end
            S_SQRT_GO: state_ff <= S_SQRT;
            S_SQRT: begin
               if (sqrt_done) begin
                  s30_ff   <= sqrt_root;
                  state_ff <= (sqrt_root == '0) ? S_LERP_MUL : S_VEC_GO;
               end
            end
            S_VEC_GO: state_ff <= S_VEC;
            S_VEC: begin
               if (cor_done) begin
                  theta_ff <= (cor_z_out < 0) ? '0 : cor_z_out[16:0];
                  state_ff <= S_ANG_MUL;
               end
            end
            S_ANG_MUL: begin
               prod_ff  <= $signed({1'b0, theta_ff}) * $signed({1'b0, frac_ff});
               state_ff <= S_ANG_SPLIT;
            end
            S_ANG_SPLIT: begin
               a2_ff    <= prod_ff[32:16];
               a1_ff    <= theta_ff - prod_ff[32:16];
               state_ff <= S_SIN1_GO;
            end
            S_SIN1_GO: state_ff <= S_SIN1;
            S_SIN1: begin
               if (cor_done) begin
                  s1_ff    <= cor_y_out[31:0];
                  state_ff <= S_SIN2_GO;
               end
            end
            S_SIN2_GO: state_ff <= S_SIN2;
            S_SIN2: begin
               if (cor_done) begin
                  s2_ff    <= cor_y_out[31:0];
                  state_ff <= S_CMP_MUL1;
               end
            end
            S_CMP_MUL1: begin
               prod_ff  <= s1_ff * a_s;
               state_ff <= S_CMP_MUL2;
            end
            S_CMP_MUL2: begin
               p2_ff    <= s2_ff * bv;
               state_ff <= S_CMP_SUM;
            end
            S_CMP_SUM: begin
               neg_ff     <= cmp_sum < 0;
               div_num_ff <= (cmp_sum < 0) ? NUM_W'(-cmp_sum) : NUM_W'(cmp_sum);
               div_den_ff <= DEN_W'(s30_ff);
               state_ff   <= S_CDIV_GO;
            end
            S_CDIV_GO: state_ff <= S_CDIV;
            S_CDIV: begin
               if (div_done) begin
                  // The quotient truncates toward zero; the sign is put back here.
                  if (neg_ff) begin
                     res_ff[res_idx] <= (div_quo > 64'd2147483648) ? 32'h8000_0000
                                                                    : 32'(-div_quo);
                  end else begin
                     res_ff[res_idx] <= (div_quo > 64'd2147483647) ? 32'h7FFF_FFFF
                                                                    : div_quo[31:0];
                  end
                  comp_ff  <= comp_ff + 1'b1;
                  state_ff <= (comp_ff == 2'd3) ? S_NEXT : S_CMP_MUL1;
               end
            end
            S_NEXT: begin
               if (tr_ff == TR_SCL) begin
                  state_ff <= S_DONE;
               end else begin
                  tr_ff    <= (tr_ff == TR_POS) ? TR_ROT : TR_SCL;
                  state_ff <= S_TRACK;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_clamped_ff <= clamp_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_clamped = rsp_clamped_ff;
   assign rsp_pos_x   = rsp_ff[0];
   assign rsp_pos_y   = rsp_ff[1];
   assign rsp_pos_z   = rsp_ff[2];
   assign rsp_rot_x   = rsp_ff[3];
   assign rsp_rot_y   = rsp_ff[4];
   assign rsp_rot_z   = rsp_ff[5];
   assign rsp_rot_w   = rsp_ff[6];
   assign rsp_scl_x   = rsp_ff[7];
   assign rsp_scl_y   = rsp_ff[8];
   assign rsp_scl_z   = rsp_ff[9];

endmodule
